>>> rtl/indexed_byte_array_store_core_macros.svh
// ----------------------------------------------------------------------------
// Byte vector store: assertion macros
// Checks are clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_BYTE_ARRAY_STORE_CORE_MACROS_SVH
`define INDEXED_BYTE_ARRAY_STORE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IBAS_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("byte vector store: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define IBAS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("byte vector store: next-cycle check failed");

`endif

>>> rtl/ibas_pkg.sv
// ----------------------------------------------------------------------------
// Byte vector store package
// Operation codes, status codes, sequencer states and the result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ibas_pkg;

	localparam int FUNC_W  = 3;
	localparam int INDEX_W = 12;
	localparam int DATA_W  = 8;
	localparam int COUNT_W = 13;

	localparam logic [FUNC_W-1:0] OP_PUSH  = 3'd0;
	localparam logic [FUNC_W-1:0] OP_POP   = 3'd1;
	localparam logic [FUNC_W-1:0] OP_GET   = 3'd2;
	localparam logic [FUNC_W-1:0] OP_SET   = 3'd3;
	localparam logic [FUNC_W-1:0] OP_ERASE = 3'd4;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD_WAIT,
		S_ER_WR,
		S_ER_CLR
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] read_data;
		status_t           status;
		logic [COUNT_W-1:0] count;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/ibas_mem.sv
// ----------------------------------------------------------------------------
// Byte vector store: element memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ibas_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [AW-1:0]              waddr,
	input  wire logic [ibas_pkg::DATA_W-1:0] wdata,
	input  wire logic                       re,
	input  wire logic [AW-1:0]              raddr,
	output logic      [ibas_pkg::DATA_W-1:0] rdata
);

	logic [ibas_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic [ibas_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/ibas_seq.sv
// ----------------------------------------------------------------------------
// Byte vector store: request sequencer
// Holds the live count, decodes requests, drives the element memory and
// walks the shift loop of erase one element per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ibas_seq #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int CW    = 13
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [ibas_pkg::FUNC_W-1:0]   func,
	input  wire logic [ibas_pkg::INDEX_W-1:0]  index,
	input  wire logic [ibas_pkg::DATA_W-1:0]   data_in,
	input  wire logic                          slot_free,
	output logic                               mem_we,
	output logic      [AW-1:0]                 mem_waddr,
	output logic      [ibas_pkg::DATA_W-1:0]   mem_wdata,
	output logic                               mem_re,
	output logic      [AW-1:0]                 mem_raddr,
	input  wire logic [ibas_pkg::DATA_W-1:0]   mem_rdata,
	output ibas_pkg::result_t                  res
);

	localparam int WW        = (CW > ibas_pkg::INDEX_W) ? CW : ibas_pkg::INDEX_W;
	localparam int PW        = CW + 1;
	localparam int CNT_OUT_W = ibas_pkg::COUNT_W;
	localparam int DW        = ibas_pkg::DATA_W;

	ibas_pkg::state_t state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic [AW-1:0]    ptr_q, ptr_d;

	logic          accept;
	logic [WW-1:0] idx_w;
	logic [WW-1:0] cnt_w;
	logic [CW-1:0] cnt_m1;
	logic          is_empty;
	logic          is_full;
	logic          in_range;
	logic          idx_is_last;
	logic          more_shift;

	assign in_stall    = !((state_q == ibas_pkg::S_IDLE) && slot_free);
	assign accept      = in_valid && !in_stall;
	assign idx_w       = WW'(index);
	assign cnt_w       = WW'(count_q);
	assign cnt_m1      = count_q - CW'(1);
	assign is_empty    = (count_q == '0);
	assign is_full     = (count_q == CW'(DEPTH));
	assign in_range    = (idx_w < cnt_w);
	assign idx_is_last = (idx_w == WW'(cnt_m1));
	// another element follows the one written this cycle
	assign more_shift  = ((PW'(ptr_q) + PW'(2)) < PW'(count_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ibas_pkg::S_IDLE: begin
				if (accept) begin
					if ((func == ibas_pkg::OP_POP) && !is_empty) begin
						state_d = ibas_pkg::S_RD_WAIT;
					end else if ((func == ibas_pkg::OP_GET) && in_range) begin
						state_d = ibas_pkg::S_RD_WAIT;
					end else if ((func == ibas_pkg::OP_ERASE) && in_range && !idx_is_last) begin
						state_d = ibas_pkg::S_ER_WR;
					end
				end
			end
			ibas_pkg::S_RD_WAIT: begin
				state_d = ibas_pkg::S_IDLE;
			end
			ibas_pkg::S_ER_WR: begin
				if (!more_shift) begin
					state_d = ibas_pkg::S_ER_CLR;
				end
			end
			ibas_pkg::S_ER_CLR: begin
				state_d = ibas_pkg::S_IDLE;
			end
			default: begin
				state_d = ibas_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		count_d       = count_q;
		ptr_d         = ptr_q;
		mem_we        = 1'b0;
		mem_waddr     = AW'(idx_w);
		mem_wdata     = data_in;
		mem_re        = 1'b0;
		mem_raddr     = AW'(idx_w);
		res.valid     = 1'b0;
		res.read_data = '0;
		res.status    = ibas_pkg::ST_OK;
		unique case (state_q)
			ibas_pkg::S_IDLE: begin
				if (accept) begin
					res.valid = 1'b1;
					unique case (func)
						ibas_pkg::OP_PUSH: begin
							if (is_full) begin
								res.status = ibas_pkg::ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(count_q);
								count_d   = count_q + CW'(1);
							end
						end
						ibas_pkg::OP_POP: begin
							if (is_empty) begin
								res.status = ibas_pkg::ST_EMPTY;
							end else begin
								// byte comes back next cycle
								res.valid = 1'b0;
								mem_re    = 1'b1;
								mem_raddr = AW'(cnt_m1);
								count_d   = cnt_m1;
							end
						end
						ibas_pkg::OP_GET: begin
							if (!in_range) begin
								res.status = ibas_pkg::ST_RANGE;
							end else begin
								res.valid = 1'b0;
								mem_re    = 1'b1;
							end
						end
						ibas_pkg::OP_SET: begin
							if (!in_range) begin
								res.status = ibas_pkg::ST_RANGE;
							end else begin
								mem_we = 1'b1;
							end
						end
						ibas_pkg::OP_ERASE: begin
							if (!in_range) begin
								res.status = ibas_pkg::ST_RANGE;
							end else if (idx_is_last) begin
								// nothing to shift: clear the vacated slot
								mem_we    = 1'b1;
								mem_wdata = '0;
								count_d   = cnt_m1;
							end else begin
								res.valid = 1'b0;
								mem_re    = 1'b1;
								mem_raddr = AW'(idx_w + WW'(1));
								ptr_d     = AW'(idx_w);
							end
						end
						default: begin
						end
					endcase
				end
			end
			ibas_pkg::S_RD_WAIT: begin
				res.valid     = 1'b1;
				res.read_data = mem_rdata;
			end
			ibas_pkg::S_ER_WR: begin
				// move element ptr+1 down and, if more follow, fetch ptr+2 in the same cycle
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = mem_rdata;
				if (more_shift) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q + AW'(2);
					ptr_d     = ptr_q + AW'(1);
				end
			end
			ibas_pkg::S_ER_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(cnt_m1);
				mem_wdata = DW'(0);
				count_d   = cnt_m1;
				res.valid = 1'b1;
			end
			default: begin
			end
		endcase
		res.count = CNT_OUT_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ibas_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
	end

endmodule

`default_nettype wire

>>> rtl/indexed_byte_array_store_core.sv
// ----------------------------------------------------------------------------
// Byte vector store core
// Fixed-capacity byte array with push, pop, get, set and erase requests.
// ----------------------------------------------------------------------------
// One request in, one result out. Push, set, every rejected request and the
// unused operation codes complete without leaving the idle state; get and pop
// wait for the element memory, which registers its read data. Erase of
// position p reads element p+1, then the single write port of the element
// memory moves one element per cycle and then clears the vacated slot; erase
// of the last element only clears its slot. A new request is taken once the
// sequencer is idle and the output register is empty or being drained in the
// same cycle. Memory contents are not cleared at reset; the live count, the
// sequencer state and the output valid flag are.
`default_nettype none

`include "indexed_byte_array_store_core_macros.svh"

module indexed_byte_array_store_core #(
	parameter int DEPTH = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [ibas_pkg::FUNC_W-1:0]   func,
	input  wire logic [ibas_pkg::INDEX_W-1:0]  index,
	input  wire logic [ibas_pkg::DATA_W-1:0]   data_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [ibas_pkg::DATA_W-1:0]   read_data,
	output logic      [1:0]                    status,
	output logic      [ibas_pkg::COUNT_W-1:0]  count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                        slot_free;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [ibas_pkg::DATA_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	logic [ibas_pkg::DATA_W-1:0] mem_rdata;
	ibas_pkg::result_t           seq_res;

	logic                         out_valid_q;
	logic [ibas_pkg::DATA_W-1:0]  read_data_q;
	ibas_pkg::status_t            status_q;
	logic [ibas_pkg::COUNT_W-1:0] count_q;

	assign slot_free = !out_valid_q || !out_stall;

	ibas_seq #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.index     (index),
		.data_in   (data_in),
		.slot_free (slot_free),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res       (seq_res)
	);

	ibas_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: hold the beat until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_res.valid) begin
			read_data_q <= seq_res.read_data;
			status_q    <= seq_res.status;
			count_q     <= seq_res.count;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign status    = status_q;
	assign count     = count_q;

	`IBAS_ASSERT_IMPLIES(a_no_overwrite, seq_res.valid, !out_valid_q || !out_stall)
	`IBAS_ASSERT_IMPLIES(a_data_only_ok, out_valid_q && (read_data_q != '0), status_q == ibas_pkg::ST_OK)
	`IBAS_ASSERT_IMPLIES(a_full_count, out_valid_q && (status_q == ibas_pkg::ST_FULL), count_q == ibas_pkg::COUNT_W'(DEPTH))
	`IBAS_ASSERT_IMPLIES(a_empty_count, out_valid_q && (status_q == ibas_pkg::ST_EMPTY), count_q == '0)
	`IBAS_ASSERT_NEXT(a_get_progress, in_valid && !in_stall && (func == ibas_pkg::OP_GET), in_stall || out_valid_q)

endmodule

`default_nettype wire
